/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check an implication on every rising edge, off while reset is low.
`define LSC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("classifier check failed");
// Check that a condition never holds, off while reset is low.
`define LSC_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("classifier forbidden condition seen");
`else
`define LSC_ASSERT(label, clk, rstn, prop)
`define LSC_NEVER(label, clk, rstn, cond)
`endif
`endif

/* rtl/lsc_pkg.sv */
// Types, constants and codes of the lookup-sum pixel classifier.
`default_nettype none
package lsc_pkg;

    localparam int PLANE_COUNT  = 4;
    localparam int BIN_BITS     = 8;
    localparam int WEIGHT_BITS  = 16;
    localparam int SEL_BITS     = 2;
    localparam int PAIR_BITS    = WEIGHT_BITS + 1;
    localparam int SCORE_BITS   = 19;
    localparam int BIAS_BITS    = 16;
    localparam int ACTIVE_BITS  = 3;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 16;

    // Item commands
    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_BIAS_OFFSET     = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_FEATURES = 1'b1;

    localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 3'd4;

    typedef logic signed [WEIGHT_BITS-1:0] coef_t;
    typedef logic        [BIN_BITS-1:0]    bin_t;

    // Control that travels with an item down the pipeline
    typedef struct packed {
        logic                   valid;
        logic                   classified;
        logic [PLANE_COUNT-1:0] lane_en;
    } lsc_ctrl_t;

endpackage
`default_nettype wire

/* rtl/lsc_ram.sv */
// Simple dual-port RAM with registered, enabled read.
`default_nettype none
module lsc_ram #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [DATA_BITS-1:0] wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    // Store one word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read one word, hold it while the read is not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/lsc_lookup.sv */
// Table write and lookup stage: one weight RAM per feature plane.
`default_nettype none
module lsc_lookup import lsc_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_cmd,
    input  wire bin_t                   feature_i [PLANE_COUNT],
    input  wire logic                   s_in_mask,
    input  wire logic [SEL_BITS-1:0]    s_table_select,
    input  wire bin_t                   s_table_index,
    input  wire coef_t                  s_table_value,
    input  wire logic [ACTIVE_BITS-1:0] active_features,
    output lsc_ctrl_t                   st1_ctrl,
    output coef_t                       st1_weight [PLANE_COUNT],
    input  wire logic                   st2_ready
);

    lsc_ctrl_t ctrl_reg;
    lsc_ctrl_t ctrl_next;
    logic      adv;
    logic      accept;

    // Advance when the stage is empty or its item moves on
    assign adv     = !ctrl_reg.valid || st2_ready;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    // Build the control of the entering item
    always_comb begin
        ctrl_next = ctrl_reg;
        if (adv) begin
            ctrl_next.valid      = accept && (s_cmd == CMD_CLASSIFY);
            ctrl_next.classified = s_in_mask;
            for (int f = 0; f < PLANE_COUNT; f++) begin
                ctrl_next.lane_en[f] = s_in_mask && (active_features > ACTIVE_BITS'(f));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= ctrl_next;
        end
    end

    assign st1_ctrl = ctrl_reg;

    // One RAM per plane; writes and reads both happen in item order
    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_bank
        logic we;
        assign we = accept && (s_cmd == CMD_WRITE)
                    && (s_table_select == SEL_BITS'(g));
        lsc_ram #(
            .ADDR_BITS (BIN_BITS),
            .DATA_BITS (WEIGHT_BITS)
        ) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (s_table_index),
            .wdata (s_table_value),
            .re    (adv),
            .raddr (feature_i[g]),
            .rdata (st1_weight[g])
        );
    end

endmodule
`default_nettype wire

/* rtl/lsc_adder.sv */
// Two-stage adder tree: pair sums, then offset plus pairs into the output register.
`default_nettype none
module lsc_adder import lsc_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire lsc_ctrl_t             st1_ctrl,
    input  wire coef_t                 st1_weight [PLANE_COUNT],
    output logic                       st2_ready,
    input  wire logic signed [BIAS_BITS-1:0] bias_offset,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [SCORE_BITS-1:0] m_score,
    output logic                       m_classified
);

    logic                        v2_reg, v2_next;
    logic                        cls2_reg, cls2_next;
    logic signed [PAIR_BITS-1:0] p01_reg, p01_next;
    logic signed [PAIR_BITS-1:0] p23_reg, p23_next;
    logic                        v3_reg, v3_next;
    logic                        cls3_reg, cls3_next;
    logic signed [SCORE_BITS-1:0] score_reg, score_next;
    logic                        adv2, adv3;
    coef_t                       lane [PLANE_COUNT];

    assign adv3      = !v3_reg || m_ready;
    assign adv2      = !v2_reg || adv3;
    assign st2_ready = adv2;

    // Drop weights of inactive or masked lanes
    always_comb begin
        for (int f = 0; f < PLANE_COUNT; f++) begin
            lane[f] = st1_ctrl.lane_en[f] ? st1_weight[f] : '0;
        end
    end

    // Pair sums
    always_comb begin
        v2_next   = v2_reg;
        cls2_next = cls2_reg;
        p01_next  = p01_reg;
        p23_next  = p23_reg;
        if (adv2) begin
            v2_next   = st1_ctrl.valid;
            cls2_next = st1_ctrl.classified;
            p01_next  = PAIR_BITS'(lane[0]) + PAIR_BITS'(lane[1]);
            p23_next  = PAIR_BITS'(lane[2]) + PAIR_BITS'(lane[3]);
        end
    end

    // Final sum, or zero for a masked-out pixel
    always_comb begin
        v3_next    = v3_reg;
        cls3_next  = cls3_reg;
        score_next = score_reg;
        if (adv3) begin
            v3_next   = v2_reg;
            cls3_next = cls2_reg;
            if (cls2_reg) begin
                score_next = SCORE_BITS'(bias_offset) + SCORE_BITS'(p01_reg)
                             + SCORE_BITS'(p23_reg);
            end else begin
                score_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        cls2_reg  <= cls2_next;
        p01_reg   <= p01_next;
        p23_reg   <= p23_next;
        cls3_reg  <= cls3_next;
        score_reg <= score_next;
    end

    assign m_valid      = v3_reg;
    assign m_score      = score_reg;
    assign m_classified = cls3_reg;

endmodule
`default_nettype wire

/* rtl/lut_sum_pixel_classifier.sv */
// Top level of the lookup-sum pixel classifier.
//
//  channel   direction  handshake          contents
//  s_        in         s_valid/s_ready    table write or pixel item
//  m_        out        m_valid/m_ready    score and classified flag
//  cfg_      in         cfg_valid/cfg_ready register index and data
//
// A pixel item passes the RAM read register, which loads at its accepting edge,
// then the pair sums, then the final sum register, before it shows on m_.
// One item is taken every cycle while m_ready does not stall the pipeline.
// A table write lands in its plane RAM at acceptance and gives no result.
// Reset clears the valid bits and bias, sets active features to 4; data regs and RAMs keep.
// A stall on m_ fills the stages one by one before s_ready falls.
`default_nettype none
`include "assert_macros.svh"
module lut_sum_pixel_classifier import lsc_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_cmd,
    input  wire logic [BIN_BITS-1:0]      s_feature_0,
    input  wire logic [BIN_BITS-1:0]      s_feature_1,
    input  wire logic [BIN_BITS-1:0]      s_feature_2,
    input  wire logic [BIN_BITS-1:0]      s_feature_3,
    input  wire logic                     s_in_mask,
    input  wire logic [SEL_BITS-1:0]      s_table_select,
    input  wire logic [BIN_BITS-1:0]      s_table_index,
    input  wire logic signed [WEIGHT_BITS-1:0] s_table_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [SCORE_BITS-1:0]  m_score,
    output logic                          m_classified,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    logic signed [BIAS_BITS-1:0]   bias_reg, bias_next;
    logic [ACTIVE_BITS-1:0]        active_reg, active_next;
    bin_t                          feature [PLANE_COUNT];
    lsc_ctrl_t                     st1_ctrl;
    coef_t                         st1_weight [PLANE_COUNT];
    logic                          st2_ready;

    assign cfg_ready = 1'b1;

    // Register writes
    always_comb begin
        bias_next   = bias_reg;
        active_next = active_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_BIAS_OFFSET:     bias_next   = cfg_wdata[BIAS_BITS-1:0];
                REG_ACTIVE_FEATURES: active_next = cfg_wdata[ACTIVE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg   <= '0;
            active_reg <= ACTIVE_RESET;
        end else begin
            bias_reg   <= bias_next;
            active_reg <= active_next;
        end
    end

    assign feature[0] = s_feature_0;
    assign feature[1] = s_feature_1;
    assign feature[2] = s_feature_2;
    assign feature[3] = s_feature_3;

    lsc_lookup u_lookup (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .feature_i       (feature),
        .s_in_mask       (s_in_mask),
        .s_table_select  (s_table_select),
        .s_table_index   (s_table_index),
        .s_table_value   (s_table_value),
        .active_features (active_reg),
        .st1_ctrl        (st1_ctrl),
        .st1_weight      (st1_weight),
        .st2_ready       (st2_ready)
    );

    lsc_adder u_adder (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .st1_ctrl     (st1_ctrl),
        .st1_weight   (st1_weight),
        .st2_ready    (st2_ready),
        .bias_offset  (bias_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_score      (m_score),
        .m_classified (m_classified)
    );

    // A masked-out pixel scores zero
    `LSC_ASSERT(a_masked_zero, aclk, aresetn,
        (m_valid && !m_classified) |-> (m_score == '0))
    // A table write never enters the adder pipeline
    `LSC_ASSERT(a_write_no_item, aclk, aresetn,
        (s_valid && s_ready && (s_cmd == CMD_WRITE)) |=> !st1_ctrl.valid)
    // A pixel item always enters the pipeline
    `LSC_ASSERT(a_pixel_enters, aclk, aresetn,
        (s_valid && s_ready && (s_cmd == CMD_CLASSIFY)) |=> st1_ctrl.valid)
    // A masked-out pixel enables no lane
    `LSC_NEVER(a_mask_lanes, aclk, aresetn,
        st1_ctrl.valid && !st1_ctrl.classified && (st1_ctrl.lane_en != '0))

endmodule
`default_nettype wire
